[rtl/core/block_deque_with_min_max_search_unit_macros.svh]
// Assertion macros used by the checker in dqmm_checker.sv.
`ifndef BLOCK_DEQUE_WITH_MIN_MAX_SEARCH_UNIT_MACROS_SVH
`define BLOCK_DEQUE_WITH_MIN_MAX_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication.
`define DQMM_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DQMM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/dqmm_pkg.sv]
`timescale 1ns / 1ps
package dqmm_pkg;

   localparam int DQMM_CAPACITY  = 16;
   localparam int DQMM_SIZE_BITS = 32;
   localparam int DQMM_TTL_BITS  = 32;

   typedef enum logic [2:0] {
      RQ_PUSH_FRONT = 3'd0,
      RQ_PUSH_BACK  = 3'd1,
      RQ_POP_FRONT  = 3'd2,
      RQ_POP_BACK   = 3'd3,
      RQ_POP_INDEX  = 3'd4,
      RQ_READ_INDEX = 3'd5,
      RQ_FIND_MIN   = 3'd6,
      RQ_FIND_MAX   = 3'd7
   } req_kind_type;

   typedef enum logic [2:0] {
      STAT_OK    = 3'd0,
      STAT_EMPTY = 3'd1,
      STAT_FULL  = 3'd2,
      STAT_RANGE = 3'd3,
      STAT_ZERO  = 3'd4
   } status_type;

   typedef struct packed {
      logic load;
      logic step;
      logic pick_max;
   } best_ctl_type;

endpackage

[rtl/core/dqmm_store.sv]
`timescale 1ns / 1ps
module dqmm_store #(
   parameter int DEPTH     = 16,
   parameter int SIZE_BITS = 32,
   parameter int TTL_BITS  = 32,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [SIZE_BITS-1:0] wr_size,
   input  logic [TTL_BITS-1:0]  wr_ttl,
   input  logic [TTL_BITS-1:0]  wr_orig,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [SIZE_BITS-1:0] rd_size,
   output logic [TTL_BITS-1:0]  rd_ttl,
   output logic [TTL_BITS-1:0]  rd_orig
);

   logic [SIZE_BITS-1:0] mem_size [DEPTH];
   logic [TTL_BITS-1:0]  mem_ttl  [DEPTH];
   logic [TTL_BITS-1:0]  mem_orig [DEPTH];

   logic [SIZE_BITS-1:0] rd_size_ff;
   logic [TTL_BITS-1:0]  rd_ttl_ff;
   logic [TTL_BITS-1:0]  rd_orig_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_size[wr_addr] <= wr_size;
         mem_ttl[wr_addr]  <= wr_ttl;
         mem_orig[wr_addr] <= wr_orig;
      end
      if (rd_en) begin
         rd_size_ff <= mem_size[rd_addr];
         rd_ttl_ff  <= mem_ttl[rd_addr];
         rd_orig_ff <= mem_orig[rd_addr];
      end
   end

   assign rd_size = rd_size_ff;
   assign rd_ttl  = rd_ttl_ff;
   assign rd_orig = rd_orig_ff;

endmodule

[rtl/core/dqmm_best.sv]
`timescale 1ns / 1ps
module dqmm_best
   import dqmm_pkg::*;
#(
   parameter int POS_BITS  = 4,
   parameter int SIZE_BITS = 32,
   parameter int TTL_BITS  = 32
) (
   input  logic                 clock,
   input  best_ctl_type         ctl,
   input  logic [SIZE_BITS-1:0] cand_size,
   input  logic [TTL_BITS-1:0]  cand_ttl,
   input  logic [TTL_BITS-1:0]  cand_orig,
   input  logic [POS_BITS-1:0]  cand_pos,
   output logic [SIZE_BITS-1:0] best_size,
   output logic [TTL_BITS-1:0]  best_ttl,
   output logic [TTL_BITS-1:0]  best_orig,
   output logic [POS_BITS-1:0]  best_pos
);

   logic [SIZE_BITS-1:0] best_size_ff;
   logic [TTL_BITS-1:0]  best_ttl_ff;
   logic [TTL_BITS-1:0]  best_orig_ff;
   logic [POS_BITS-1:0]  best_pos_ff;
   logic                 greater;
   logic                 take;

   assign greater = cand_size > best_size_ff;
   assign take    = ctl.load | (ctl.step & (ctl.pick_max ? greater : !greater));

   always_ff @(posedge clock) begin
      if (take) begin
         best_size_ff <= cand_size;
         best_ttl_ff  <= cand_ttl;
         best_orig_ff <= cand_orig;
         best_pos_ff  <= cand_pos;
      end
   end

   assign best_size = best_size_ff;
   assign best_ttl  = best_ttl_ff;
   assign best_orig = best_orig_ff;
   assign best_pos  = best_pos_ff;

endmodule

[rtl/core/block_deque_with_min_max_search_unit.sv]
`timescale 1ns / 1ps
// Bounded deque of block records (size, ttl, original ttl) kept as a ring in one
// memory with a single read port and a single write port; one request is taken at
// a time and gives one response beat. A push, or any request that fails its
// check, responds in the cycle after acceptance; pop front, pop back and read index
// pass through the fetch state; pop index at position p also takes one shift state
// per entry moved down to close the gap (n - 1 - p of them, n being the fill level
// before the request); find min and find max read one entry per step, in the fetch
// and scan states, through one size comparator. Between response and next request
// the response beat must be taken. After reset the deque is empty and ready at once.
module block_deque_with_min_max_search_unit
   import dqmm_pkg::*;
#(
   parameter int CAPACITY  = DQMM_CAPACITY,
   parameter int SIZE_BITS = DQMM_SIZE_BITS,
   parameter int TTL_BITS  = DQMM_TTL_BITS,
   localparam int POS_BITS = $clog2(CAPACITY),
   localparam int CNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_type,
   input  logic [SIZE_BITS-1:0]       req_block_size,
   input  logic signed [TTL_BITS-1:0] req_time_to_live,
   input  logic [POS_BITS-1:0]        req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic [CNT_BITS-1:0]        rsp_fill_level,
   output logic [SIZE_BITS-1:0]       rsp_result_size,
   output logic signed [TTL_BITS-1:0] rsp_result_ttl,
   output logic signed [TTL_BITS-1:0] rsp_result_ttl_original,
   output logic [POS_BITS-1:0]        rsp_result_position
);

   localparam int SUM_BITS = CNT_BITS + 1;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FETCH = 5'b00010,
      S_SCAN  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   function automatic logic [POS_BITS-1:0] phys(input logic [POS_BITS-1:0] head,
                                                input logic [CNT_BITS-1:0] lg);
      logic [SUM_BITS-1:0] sum;
      sum = SUM_BITS'(head) + SUM_BITS'(lg);
      if (sum >= SUM_BITS'(CAPACITY)) begin
         sum = sum - SUM_BITS'(CAPACITY);
      end
      return POS_BITS'(sum);
   endfunction

   state_type            state_ff, state_in;
   req_kind_type         op_ff, op_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [POS_BITS-1:0]  head_ff, head_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   status_type           status_ff, status_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [TTL_BITS-1:0]  ttl_ff, ttl_in;
   logic [TTL_BITS-1:0]  orig_ff, orig_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic                 from_best_ff, from_best_in;

   req_kind_type         req_kind;
   logic [POS_BITS-1:0]  head_dec;
   logic [POS_BITS-1:0]  head_inc;
   logic [CNT_BITS-1:0]  count_dec;

   logic                 wr_en;
   logic [POS_BITS-1:0]  wr_addr;
   logic [SIZE_BITS-1:0] wr_size;
   logic [TTL_BITS-1:0]  wr_ttl;
   logic [TTL_BITS-1:0]  wr_orig;
   logic                 rd_en;
   logic [POS_BITS-1:0]  rd_addr;
   logic [SIZE_BITS-1:0] rd_size;
   logic [TTL_BITS-1:0]  rd_ttl;
   logic [TTL_BITS-1:0]  rd_orig;

   best_ctl_type         best_ctl;
   logic [SIZE_BITS-1:0] best_size;
   logic [TTL_BITS-1:0]  best_ttl;
   logic [TTL_BITS-1:0]  best_orig;
   logic [POS_BITS-1:0]  best_pos;

   assign req_kind  = req_kind_type'(req_type);
   assign head_dec  = (head_ff == '0) ? POS_BITS'(CAPACITY - 1) : head_ff - POS_BITS'(1);
   assign head_inc  = (head_ff == POS_BITS'(CAPACITY - 1)) ? '0 : head_ff + POS_BITS'(1);
   assign count_dec = count_ff - CNT_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      size_in      = size_ff;
      ttl_in       = ttl_ff;
      orig_in      = orig_ff;
      pos_in       = pos_ff;
      from_best_in = from_best_ff;
      wr_en        = 1'b0;
      wr_addr      = phys(head_ff, idx_ff);
      wr_size      = req_block_size;
      wr_ttl       = req_time_to_live;
      wr_orig      = req_time_to_live;
      rd_en        = 1'b0;
      rd_addr      = phys(head_ff, idx_ff + CNT_BITS'(1));
      best_ctl     = '0;
      best_ctl.pick_max = (op_ff == RQ_FIND_MAX);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_kind;
               from_best_in = 1'b0;
               status_in    = STAT_OK;
               size_in      = '0;
               ttl_in       = '0;
               orig_in      = '0;
               pos_in       = '0;
               unique case (req_kind)
                  RQ_PUSH_FRONT, RQ_PUSH_BACK: begin
                     state_in = S_DONE;
                     if (req_block_size == '0) begin
                        status_in = STAT_ZERO;
                     end else if (count_ff == CNT_BITS'(CAPACITY)) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_BITS'(1);
                        size_in  = req_block_size;
                        ttl_in   = req_time_to_live;
                        orig_in  = req_time_to_live;
                        if (req_kind == RQ_PUSH_FRONT) begin
                           wr_addr = head_dec;
                           head_in = head_dec;
                        end else begin
                           wr_addr = phys(head_ff, count_ff);
                           pos_in  = POS_BITS'(count_ff);
                        end
                     end
                  end
                  RQ_POP_FRONT, RQ_POP_BACK, RQ_FIND_MIN, RQ_FIND_MAX: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        idx_in   = (req_kind == RQ_POP_BACK) ? count_dec : '0;
                        rd_en    = 1'b1;
                        rd_addr  = phys(head_ff, idx_in);
                        state_in = S_FETCH;
                     end
                  end
                  RQ_POP_INDEX, RQ_READ_INDEX: begin
                     if (CNT_BITS'(req_position) >= count_ff) begin
                        status_in = STAT_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        idx_in   = CNT_BITS'(req_position);
                        rd_en    = 1'b1;
                        rd_addr  = phys(head_ff, idx_in);
                        state_in = S_FETCH;
                     end
                  end
               endcase
            end
         end
         S_FETCH: begin
            rd_en   = 1'b1;
            size_in = rd_size;
            ttl_in  = rd_ttl;
            orig_in = rd_orig;
            pos_in  = POS_BITS'(idx_ff);
            unique case (op_ff)
               RQ_FIND_MIN, RQ_FIND_MAX: begin
                  best_ctl.load = 1'b1;
                  if (idx_ff == count_dec) begin
                     from_best_in = 1'b1;
                     state_in     = S_DONE;
                  end else begin
                     idx_in   = idx_ff + CNT_BITS'(1);
                     state_in = S_SCAN;
                  end
               end
               RQ_POP_FRONT: begin
                  head_in  = head_inc;
                  count_in = count_dec;
                  state_in = S_DONE;
               end
               RQ_POP_BACK: begin
                  count_in = count_dec;
                  state_in = S_DONE;
               end
               RQ_POP_INDEX: begin
                  if (idx_ff == count_dec) begin
                     count_in = count_dec;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SHIFT;
                  end
               end
               RQ_READ_INDEX, RQ_PUSH_FRONT, RQ_PUSH_BACK: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            best_ctl.step = 1'b1;
            rd_en         = 1'b1;
            if (idx_ff == count_dec) begin
               from_best_in = 1'b1;
               state_in     = S_DONE;
            end else begin
               idx_in = idx_ff + CNT_BITS'(1);
            end
         end
         S_SHIFT: begin
            // move entry idx+1 down to idx, fetch idx+2 meanwhile
            wr_en   = 1'b1;
            wr_size = rd_size;
            wr_ttl  = rd_ttl;
            wr_orig = rd_orig;
            rd_en   = 1'b1;
            rd_addr = phys(head_ff, idx_ff + CNT_BITS'(2));
            if (idx_ff == count_ff - CNT_BITS'(2)) begin
               count_in = count_dec;
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + CNT_BITS'(1);
            end
         end
         S_DONE: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         from_best_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         from_best_ff <= from_best_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      size_ff   <= size_in;
      ttl_ff    <= ttl_in;
      orig_ff   <= orig_in;
      pos_ff    <= pos_in;
   end

   dqmm_store #(
      .DEPTH     (CAPACITY),
      .SIZE_BITS (SIZE_BITS),
      .TTL_BITS  (TTL_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_size (wr_size),
      .wr_ttl  (wr_ttl),
      .wr_orig (wr_orig),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_size (rd_size),
      .rd_ttl  (rd_ttl),
      .rd_orig (rd_orig)
   );

   dqmm_best #(
      .POS_BITS  (POS_BITS),
      .SIZE_BITS (SIZE_BITS),
      .TTL_BITS  (TTL_BITS)
   ) u_best (
      .clock     (clock),
      .ctl       (best_ctl),
      .cand_size (rd_size),
      .cand_ttl  (rd_ttl),
      .cand_orig (rd_orig),
      .cand_pos  (POS_BITS'(idx_ff)),
      .best_size (best_size),
      .best_ttl  (best_ttl),
      .best_orig (best_orig),
      .best_pos  (best_pos)
   );

   assign req_stall               = (state_ff != S_IDLE);
   assign rsp_valid               = (state_ff == S_DONE);
   assign rsp_status              = status_ff;
   assign rsp_fill_level          = count_ff;
   assign rsp_result_size         = from_best_ff ? best_size : size_ff;
   assign rsp_result_ttl          = from_best_ff ? best_ttl : ttl_ff;
   assign rsp_result_ttl_original = from_best_ff ? best_orig : orig_ff;
   assign rsp_result_position     = from_best_ff ? best_pos : pos_ff;

endmodule

[rtl/core/dqmm_checker.sv]
`timescale 1ns / 1ps
`include "block_deque_with_min_max_search_unit_macros.svh"
module dqmm_checker
   import dqmm_pkg::*;
#(
   parameter int CAPACITY  = DQMM_CAPACITY,
   parameter int SIZE_BITS = DQMM_SIZE_BITS,
   parameter int TTL_BITS  = DQMM_TTL_BITS,
   localparam int POS_BITS = $clog2(CAPACITY),
   localparam int CNT_BITS = $clog2(CAPACITY + 1)
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [2:0]                 rsp_status,
   input logic [CNT_BITS-1:0]        rsp_fill_level,
   input logic [SIZE_BITS-1:0]       rsp_result_size,
   input logic signed [TTL_BITS-1:0] rsp_result_ttl,
   input logic signed [TTL_BITS-1:0] rsp_result_ttl_original,
   input logic [POS_BITS-1:0]        rsp_result_position
);

   `DQMM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_result_size) && $stable(rsp_result_position), "stalled response beat changed")
   `DQMM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request beat taken while previous one in flight")
   `DQMM_ASSERT_NOW(a_no_accept_with_rsp, clock, reset, rsp_valid, req_stall, "request open while response pending")
   `DQMM_ASSERT_NOW(a_error_fields_zero, clock, reset, rsp_valid && (rsp_status != STAT_OK), (rsp_result_size == '0) && (rsp_result_ttl == '0) && (rsp_result_ttl_original == '0) && (rsp_result_position == '0), "error response carries entry data")
   `DQMM_ASSERT_NOW(a_fill_bound, clock, reset, rsp_valid, rsp_fill_level <= CNT_BITS'(CAPACITY), "fill level beyond capacity")

endmodule

bind block_deque_with_min_max_search_unit dqmm_checker #(
   .CAPACITY  (CAPACITY),
   .SIZE_BITS (SIZE_BITS),
   .TTL_BITS  (TTL_BITS)
) u_dqmm_checker (.*);

[dv/block_deque_with_min_max_search_unit_checker.sv]
`timescale 1ns / 1ps
module block_deque_with_min_max_search_unit_checker
   import dqmm_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [2:0]                      req_type,
   input  logic [DQMM_SIZE_BITS-1:0]       req_block_size,
   input  logic signed [DQMM_TTL_BITS-1:0] req_time_to_live,
   input  logic [3:0]                      req_position,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [2:0]                      rsp_status,
   input  logic [4:0]                      rsp_fill_level,
   input  logic [DQMM_SIZE_BITS-1:0]       rsp_result_size,
   input  logic signed [DQMM_TTL_BITS-1:0] rsp_result_ttl,
   input  logic signed [DQMM_TTL_BITS-1:0] rsp_result_ttl_original,
   input  logic [3:0]                      rsp_result_position,
   output int                              error_count,
   output int                              outstanding
);

   typedef struct {
      status_type                      status;
      logic [4:0]                      fill;
      logic [DQMM_SIZE_BITS-1:0]       size;
      logic signed [DQMM_TTL_BITS-1:0] ttl;
      logic signed [DQMM_TTL_BITS-1:0] ttl_orig;
      logic [3:0]                      pos;
   } deque_reply_type;

   logic [DQMM_SIZE_BITS-1:0]       block_sizes [DQMM_CAPACITY];
   logic signed [DQMM_TTL_BITS-1:0] block_ttls [DQMM_CAPACITY];
   logic signed [DQMM_TTL_BITS-1:0] block_ttl_origs [DQMM_CAPACITY];
   int                              block_fill = 0;
   deque_reply_type                 expected_replies [$];
   int                              failures = 0;

   function automatic void close_gap_at(int at);
      for (int i = at; i < block_fill - 1; i++) begin
         block_sizes[i]     = block_sizes[i+1];
         block_ttls[i]      = block_ttls[i+1];
         block_ttl_origs[i] = block_ttl_origs[i+1];
      end
      block_fill--;
   endfunction

   function automatic deque_reply_type predict_reply(req_kind_type kind,
                                                     logic [DQMM_SIZE_BITS-1:0] size,
                                                     logic signed [DQMM_TTL_BITS-1:0] ttl,
                                                     logic [3:0] pos);
      deque_reply_type r;
      int              at;
      int              best;
      bit              have;
      r.status = STAT_OK;
      at = 0;
      have = 1'b0;
      case (kind)
         RQ_PUSH_FRONT, RQ_PUSH_BACK: begin
            if (size == '0) begin
               r.status = STAT_ZERO;
            end else if (block_fill >= DQMM_CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               if (kind == RQ_PUSH_FRONT) begin
                  for (int i = block_fill; i > 0; i--) begin
                     block_sizes[i]     = block_sizes[i-1];
                     block_ttls[i]      = block_ttls[i-1];
                     block_ttl_origs[i] = block_ttl_origs[i-1];
                  end
                  at = 0;
               end else begin
                  at = block_fill;
               end
               block_sizes[at]     = size;
               block_ttls[at]      = ttl;
               block_ttl_origs[at] = ttl;
               block_fill++;
               have = 1'b1;
            end
         end
         RQ_POP_FRONT, RQ_POP_BACK, RQ_FIND_MIN, RQ_FIND_MAX: begin
            if (block_fill == 0) begin
               r.status = STAT_EMPTY;
            end else if (kind == RQ_POP_FRONT || kind == RQ_POP_BACK) begin
               at = (kind == RQ_POP_FRONT) ? 0 : block_fill - 1;
               have = 1'b1;
            end else begin
               best = 0;
               for (int i = 1; i < block_fill; i++) begin
                  if (kind == RQ_FIND_MAX) begin
                     if (block_sizes[i] > block_sizes[best]) best = i;
                  end else begin
                     if (block_sizes[i] <= block_sizes[best]) best = i;
                  end
               end
               at = best;
               have = 1'b1;
            end
         end
         default: begin
            if (int'(pos) >= block_fill) begin
               r.status = STAT_RANGE;
            end else begin
               at = int'(pos);
               have = 1'b1;
            end
         end
      endcase
      if (have) begin
         r.size     = block_sizes[at];
         r.ttl      = block_ttls[at];
         r.ttl_orig = block_ttl_origs[at];
         r.pos      = at[3:0];
         if (kind == RQ_POP_FRONT || kind == RQ_POP_BACK || kind == RQ_POP_INDEX) begin
            close_gap_at(at);
         end
      end else begin
         r.size     = '0;
         r.ttl      = '0;
         r.ttl_orig = '0;
         r.pos      = '0;
      end
      r.fill = block_fill[4:0];
      return r;
   endfunction

   always @(posedge clock) begin
      deque_reply_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("%0t: response beat with nothing expected: status %0d fill %0d",
                           $realtime, rsp_status, rsp_fill_level);
               end
            end else begin
               want = expected_replies.pop_front();
               if (want.status !== rsp_status || want.fill !== rsp_fill_level ||
                   want.size !== rsp_result_size || want.ttl !== rsp_result_ttl ||
                   want.ttl_orig !== rsp_result_ttl_original ||
                   want.pos !== rsp_result_position) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("%0t: mismatch expected st %0d fill %0d size %h ttl %h orig %h pos %0d",
                              $realtime, want.status, want.fill, want.size, want.ttl,
                              want.ttl_orig, want.pos);
                     $display("%0t:          actual   st %0d fill %0d size %h ttl %h orig %h pos %0d",
                              $realtime, rsp_status, rsp_fill_level, rsp_result_size,
                              rsp_result_ttl, rsp_result_ttl_original, rsp_result_position);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_replies.push_back(predict_reply(req_kind_type'(req_type), req_block_size,
                                                     req_time_to_live, req_position));
         end
      end
      error_count <= failures;
      outstanding <= expected_replies.size();
   end

endmodule

[dv/tb_block_deque_with_min_max_search_unit.sv]
`timescale 1ns / 1ps
module tb_block_deque_with_min_max_search_unit;
   import dqmm_pkg::*;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [2:0]                      req_type = '0;
   logic [DQMM_SIZE_BITS-1:0]       req_block_size = '0;
   logic signed [DQMM_TTL_BITS-1:0] req_time_to_live = '0;
   logic [3:0]                      req_position = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [2:0]                      rsp_status;
   logic [4:0]                      rsp_fill_level;
   logic [DQMM_SIZE_BITS-1:0]       rsp_result_size;
   logic signed [DQMM_TTL_BITS-1:0] rsp_result_ttl;
   logic signed [DQMM_TTL_BITS-1:0] rsp_result_ttl_original;
   logic [3:0]                      rsp_result_position;
   int                              error_count;
   int                              outstanding;
   int                              send_idle_pct = 0;
   int                              rsp_idle_pct = 0;
   int                              beats_sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   block_deque_with_min_max_search_unit i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_type                (req_type),
      .req_block_size          (req_block_size),
      .req_time_to_live        (req_time_to_live),
      .req_position            (req_position),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_status              (rsp_status),
      .rsp_fill_level          (rsp_fill_level),
      .rsp_result_size         (rsp_result_size),
      .rsp_result_ttl          (rsp_result_ttl),
      .rsp_result_ttl_original (rsp_result_ttl_original),
      .rsp_result_position     (rsp_result_position)
   );

   block_deque_with_min_max_search_unit_checker i_checker (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_type                (req_type),
      .req_block_size          (req_block_size),
      .req_time_to_live        (req_time_to_live),
      .req_position            (req_position),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_status              (rsp_status),
      .rsp_fill_level          (rsp_fill_level),
      .rsp_result_size         (rsp_result_size),
      .rsp_result_ttl          (rsp_result_ttl),
      .rsp_result_ttl_original (rsp_result_ttl_original),
      .rsp_result_position     (rsp_result_position),
      .error_count             (error_count),
      .outstanding             (outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   function automatic logic [DQMM_SIZE_BITS-1:0] pick_size(bit allow_zero);
      logic [DQMM_SIZE_BITS-1:0] s;
      case ($urandom_range(7))
         0, 1:    s = $urandom_range(1, 4);
         2:       s = '1;
         3:       s = 1;
         default: s = $urandom;
      endcase
      if (allow_zero && $urandom_range(15) == 0) s = '0;
      if (!allow_zero && s == '0) s = 1;
      return s;
   endfunction

   function automatic logic signed [DQMM_TTL_BITS-1:0] pick_ttl();
      case ($urandom_range(7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return -1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(req_kind_type kind, logic [DQMM_SIZE_BITS-1:0] size,
                               logic signed [DQMM_TTL_BITS-1:0] ttl, logic [3:0] pos);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_block_size   <= size;
      req_time_to_live <= ttl;
      req_position     <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic run_phase(int send_pct, int rsp_pct, int beats);
      int           stop_at;
      int           n;
      req_kind_type kind;
      send_idle_pct = send_pct;
      rsp_idle_pct <= rsp_pct;
      stop_at = beats_sent + beats;
      while (beats_sent < stop_at) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               n = 17 + $urandom_range(0, 3);
               repeat (n) begin
                  kind = $urandom_range(1) ? RQ_PUSH_BACK : RQ_PUSH_FRONT;
                  send_request(kind, pick_size(1'b0), pick_ttl(), 4'($urandom_range(15)));
               end
            end
            3, 4: begin
               n = 16 + $urandom_range(1, 3);
               repeat (n) begin
                  case ($urandom_range(3))
                     0: send_request(RQ_POP_FRONT, $urandom, $urandom,
                                     4'($urandom_range(15)));
                     1: send_request(RQ_POP_BACK, $urandom, $urandom,
                                     4'($urandom_range(15)));
                     2: send_request(RQ_POP_INDEX, $urandom, $urandom,
                                     4'($urandom_range(15)));
                     default: send_request(RQ_POP_INDEX, $urandom, $urandom, 4'd0);
                  endcase
               end
            end
            default: begin
               repeat (8) begin
                  kind = req_kind_type'($urandom_range(7));
                  send_request(kind, pick_size(1'b1), pick_ttl(),
                               4'($urandom_range(1) ? $urandom_range(15) : $urandom_range(3)));
               end
            end
         endcase
      end
      wait_for_replies();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 33;
      rsp_idle_pct <= 83;
      @(posedge clock);

      send_request(RQ_POP_FRONT, '0, '0, 4'd0);
      send_request(RQ_POP_BACK, '0, '0, 4'd0);
      send_request(RQ_FIND_MIN, '0, '0, 4'd0);
      send_request(RQ_FIND_MAX, '0, '0, 4'd0);
      send_request(RQ_POP_INDEX, '0, '0, 4'd0);
      send_request(RQ_READ_INDEX, '0, '0, 4'd15);
      send_request(RQ_PUSH_FRONT, '0, 32'sd5, 4'd0);
      send_request(RQ_PUSH_BACK, '0, -1, 4'd15);
      send_request(RQ_PUSH_BACK, '1, 32'sh8000_0000, 4'd0);
      send_request(RQ_PUSH_FRONT, 32'd1, 32'sh7FFF_FFFF, 4'd0);
      send_request(RQ_PUSH_BACK, 32'd5, -1, 4'd0);
      send_request(RQ_PUSH_BACK, 32'd1, 32'sd0, 4'd0);
      send_request(RQ_PUSH_FRONT, '1, 32'sd3, 4'd0);
      send_request(RQ_FIND_MAX, '0, '0, 4'd0);
      send_request(RQ_FIND_MIN, '0, '0, 4'd0);
      send_request(RQ_READ_INDEX, '0, '0, 4'd2);
      send_request(RQ_READ_INDEX, '0, '0, 4'd5);
      send_request(RQ_READ_INDEX, '0, '0, 4'd4);
      send_request(RQ_POP_INDEX, '0, '0, 4'd1);
      send_request(RQ_POP_INDEX, '0, '0, 4'd3);
      send_request(RQ_POP_FRONT, '0, '0, 4'd0);
      send_request(RQ_POP_BACK, '0, '0, 4'd0);
      send_request(RQ_POP_INDEX, '0, '0, 4'd0);
      wait_for_replies();

      run_phase(33, 83, 130);
      run_phase(83, 33, 130);
      run_phase(0, 0, 140);

      if (error_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
